// File: hw/rtl/awm_pkg.sv
package awm_pkg;

    typedef struct packed {
        logic       shift_s;
        logic       shift_p;
        logic       fill;
        logic [1:0] chan;
    } t_cell_ctl;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_DIVF  = 8'b0000_0100,
        S_FILL  = 8'b0000_1000,
        S_DIVW  = 8'b0001_0000,
        S_PUSHP = 8'b0010_0000,
        S_DIVP  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

endpackage

// File: hw/rtl/awm_cell.sv
module awm_cell
    import awm_pkg::*;
#(
    parameter int NC = 4,
    parameter int SB = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [SB-1:0]          i_fill_val,
    input  logic [NC-1:0][SB-1:0]  i_s_next,
    input  logic [NC-1:0][SB-1:0]  i_p_next,
    output logic [NC-1:0][SB-1:0]  o_s,
    output logic [NC-1:0][SB-1:0]  o_p
);

    logic [NC-1:0][SB-1:0] r_s;
    logic [NC-1:0][SB-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_p <= '0;
        end else begin
            for (int j = 0; j < NC; j++) begin
                if (int'(i_ctl.chan) == j) begin
                    if (i_ctl.fill) begin
                        r_s[j] <= i_fill_val;
                        r_p[j] <= i_fill_val;
                    end else begin
                        if (i_ctl.shift_s) r_s[j] <= i_s_next[j];
                        if (i_ctl.shift_p) r_p[j] <= i_p_next[j];
                    end
                end
            end
        end
    end

    assign o_s = r_s;
    assign o_p = r_p;

endmodule

// File: hw/rtl/awm_div.sv
module awm_div
    import awm_pkg::*;
#(
    parameter int NUMW = 21,
    parameter int SB   = 12,
    parameter int D0   = 64,
    parameter int D1   = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_sel,
    input  logic [NUMW-1:0] i_num,
    output logic            o_done,
    output logic [SB-1:0]   o_q
);

    localparam int L0 = $clog2(D0);
    localparam int L1 = $clog2(D1);
    localparam int K0 = NUMW + L0;
    localparam int K1 = NUMW + L1;
    localparam int MW = NUMW + 1;
    localparam int PW = NUMW + MW;
    localparam logic [63:0] M0 = ((64'd1 << K0) + 64'(D0) - 64'd1) / 64'(D0);
    localparam logic [63:0] M1 = ((64'd1 << K1) + 64'(D1) - 64'd1) / 64'(D1);

    logic [MW-1:0] w_m;
    logic [PW-1:0] w_prod;
    logic [SB-1:0] w_q;
    logic [SB-1:0] r_q;
    logic          r_done;

    // quotient by reciprocal multiplication, exact for every numerator of NUMW bits
    assign w_m    = i_sel ? M1[MW-1:0] : M0[MW-1:0];
    assign w_prod = PW'(i_num) * PW'(w_m);
    assign w_q    = i_sel ? SB'(w_prod >> K1) : SB'(w_prod >> K0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_q <= w_q;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// File: hw/rtl/adc_window_mean_and_peak_average_unit.sv
// channel | direction | handshake                    | payload
// input   | in        | i_in_valid / o_in_stall      | i_chan, i_sample
// output  | out       | o_out_valid / i_out_stall    | o_out_chan, o_window_mean,
//         |           |                              | o_peak_mean, o_ready_res
// one item at a time; the window of the item's channel is rotated once through the cell row
// the item that starts a channel passes scan, divide, fill and output; an item of a started
// channel passes scan, divide, peak push, divide and output; each divide has a registered start and done
// an item that triggers no rotation goes straight to output; an unused channel number is dropped
// synchronous active-low reset clears all windows, sums, started flags and the output valid at once
// a result held by output stall keeps the next item waiting in the output state
module adc_window_mean_and_peak_average_unit
    import awm_pkg::*;
#(
    parameter int WINDOW_LEN   = 256,
    parameter int START_COUNT  = 64,
    parameter int NUM_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_chan,
    input  logic [11:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_chan,
    output logic [11:0] o_window_mean,
    output logic [11:0] o_peak_mean,
    output logic        o_ready_res
);

    localparam int W    = WINDOW_LEN;
    localparam int NC   = NUM_CHANNELS;
    localparam int SB   = SAMPLE_BITS;
    localparam int NZW  = $clog2(W + 1);
    localparam int SUMW = SB + NZW;
    localparam int CNTW = $clog2(W);
    localparam int CIW  = (NC > 1) ? $clog2(NC) : 1;

    logic [NC-1:0][SB-1:0] w_s [0:W];
    logic [NC-1:0][SB-1:0] w_p [0:W];

    t_cell_ctl     w_ctl;
    logic [SB-1:0] w_tail_s;
    logic [SB-1:0] w_tail_p;

    t_state        r_state, n_state;
    logic [1:0]    r_chan, n_chan;
    logic [SB-1:0] r_s, n_s;
    logic [SB-1:0] r_mx, n_mx;
    logic [SUMW-1:0] r_part, n_part;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [SB-1:0] r_wm, n_wm;
    logic [SB-1:0] r_pm, n_pm;
    logic          r_rdy, n_rdy;
    logic          r_dgo, n_dgo;
    logic          r_ov, n_ov;
    logic [1:0]    r_ochan, n_ochan;
    logic [SB-1:0] r_owm, n_owm;
    logic [SB-1:0] r_opm, n_opm;
    logic          r_ordy, n_ordy;

    logic [SUMW-1:0] r_ssum [NC];
    logic [SUMW-1:0] n_ssum [NC];
    logic [SUMW-1:0] r_psum [NC];
    logic [SUMW-1:0] n_psum [NC];
    logic [NZW-1:0]  r_nz   [NC];
    logic [NZW-1:0]  n_nz   [NC];
    logic [SB-1:0]   r_lpm  [NC];
    logic [SB-1:0]   n_lpm  [NC];
    logic [NC-1:0]   r_started, n_started;

    logic [SUMW-1:0] w_dnum;
    logic            w_dsel;
    logic            w_ddone;
    logic [SB-1:0]   w_dq;

    logic [CIW-1:0]  w_ci;
    logic [CIW-1:0]  w_ri;
    logic [SB-1:0]   w_head_s;
    logic [SB-1:0]   w_head_p;
    logic [NZW-1:0]  w_nz_new;
    logic            w_acc;

    assign w_s[W] = {NC{w_tail_s}};
    assign w_p[W] = {NC{w_tail_p}};

    for (genvar g = 0; g < W; g++) begin : g_cell
        awm_cell #(
            .NC(NC),
            .SB(SB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_fill_val (w_dq),
            .i_s_next   (w_s[g+1]),
            .i_p_next   (w_p[g+1]),
            .o_s        (w_s[g]),
            .o_p        (w_p[g])
        );
    end

    awm_div #(
        .NUMW(SUMW),
        .SB  (SB),
        .D0  (START_COUNT),
        .D1  (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dgo),
        .i_sel   (w_dsel),
        .i_num   (w_dnum),
        .o_done  (w_ddone),
        .o_q     (w_dq)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_ci       = CIW'(i_chan);
    assign w_ri       = CIW'(r_chan);
    assign w_head_s   = w_s[0][(r_state == S_IDLE) ? w_ci : w_ri];
    assign w_head_p   = w_p[0][w_ri];

    always_comb begin
        w_dnum = r_part;
        w_dsel = 1'b0;
        if (r_state == S_DIVW) begin
            w_dnum = r_ssum[w_ri];
            w_dsel = 1'b1;
        end else if (r_state == S_DIVP) begin
            w_dnum = r_psum[w_ri];
            w_dsel = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_chan    = r_chan;
        n_s       = r_s;
        n_mx      = r_mx;
        n_part    = r_part;
        n_cnt     = r_cnt;
        n_wm      = r_wm;
        n_pm      = r_pm;
        n_rdy     = r_rdy;
        n_dgo     = 1'b0;
        n_ssum    = r_ssum;
        n_psum    = r_psum;
        n_nz      = r_nz;
        n_lpm     = r_lpm;
        n_started = r_started;
        n_ochan   = r_ochan;
        n_owm     = r_owm;
        n_opm     = r_opm;
        n_ordy    = r_ordy;
        n_ov      = r_ov && i_out_stall;
        w_ctl     = '{shift_s: 1'b0, shift_p: 1'b0, fill: 1'b0, chan: r_chan};
        w_tail_s  = w_head_s;
        w_tail_p  = r_mx;
        w_nz_new  = r_nz[w_ci];

        unique case (r_state)
            S_IDLE: begin
                if (w_acc && int'(i_chan) < NC) begin
                    n_chan        = i_chan;
                    n_s           = SB'(i_sample);
                    w_ctl.shift_s = 1'b1;
                    w_ctl.chan    = i_chan;
                    w_tail_s      = SB'(i_sample);
                    n_ssum[w_ci]  = r_ssum[w_ci] - SUMW'(w_head_s) + SUMW'(SB'(i_sample));
                    n_cnt         = '0;
                    n_mx          = '0;
                    n_part        = '0;
                    if (r_started[w_ci]) begin
                        n_state = S_SCAN;
                    end else begin
                        if (w_head_s != '0 && w_nz_new != '0) w_nz_new = w_nz_new - 1'b1;
                        if (SB'(i_sample) != '0) w_nz_new = w_nz_new + 1'b1;
                        n_nz[w_ci] = w_nz_new;
                        if (START_COUNT <= W && int'(w_nz_new) >= START_COUNT) begin
                            n_state = S_SCAN;
                        end else begin
                            n_wm    = SB'(i_sample);
                            n_pm    = r_lpm[w_ci];
                            n_rdy   = 1'b0;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_ctl.shift_s = 1'b1;
                if (w_head_s > r_mx) n_mx = w_head_s;
                if (int'(r_cnt) >= W - START_COUNT) n_part = r_part + SUMW'(w_head_s);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(W - 1)) begin
                    n_dgo   = 1'b1;
                    n_state = r_started[w_ri] ? S_DIVW : S_DIVF;
                end
            end
            S_DIVF: begin
                if (w_ddone) n_state = S_FILL;
            end
            S_FILL: begin
                w_ctl.fill        = 1'b1;
                n_ssum[w_ri]      = SUMW'(w_dq) * SUMW'(W);
                n_psum[w_ri]      = SUMW'(w_dq) * SUMW'(W);
                n_nz[w_ri]        = (w_dq != '0) ? NZW'(W) : '0;
                n_started[w_ri]   = 1'b1;
                n_lpm[w_ri]       = w_dq;
                n_wm              = r_s;
                n_pm              = w_dq;
                n_rdy             = 1'b0;
                n_state           = S_OUT;
            end
            S_DIVW: begin
                if (w_ddone) begin
                    n_wm    = w_dq;
                    n_state = S_PUSHP;
                end
            end
            S_PUSHP: begin
                w_ctl.shift_p = 1'b1;
                n_psum[w_ri]  = r_psum[w_ri] - SUMW'(w_head_p) + SUMW'(r_mx);
                n_dgo         = 1'b1;
                n_state       = S_DIVP;
            end
            S_DIVP: begin
                if (w_ddone) begin
                    n_pm        = w_dq;
                    n_lpm[w_ri] = w_dq;
                    n_rdy       = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_ochan = r_chan;
                    n_owm   = r_wm;
                    n_opm   = r_pm;
                    n_ordy  = r_rdy;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dgo     <= 1'b0;
            r_ov      <= 1'b0;
            r_started <= '0;
            for (int j = 0; j < NC; j++) begin
                r_ssum[j] <= '0;
                r_psum[j] <= '0;
                r_nz[j]   <= '0;
                r_lpm[j]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_dgo     <= n_dgo;
            r_ov      <= n_ov;
            r_started <= n_started;
            r_ssum    <= n_ssum;
            r_psum    <= n_psum;
            r_nz      <= n_nz;
            r_lpm     <= n_lpm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan  <= n_chan;
        r_s     <= n_s;
        r_mx    <= n_mx;
        r_part  <= n_part;
        r_cnt   <= n_cnt;
        r_wm    <= n_wm;
        r_pm    <= n_pm;
        r_rdy   <= n_rdy;
        r_ochan <= n_ochan;
        r_owm   <= n_owm;
        r_opm   <= n_opm;
        r_ordy  <= n_ordy;
    end

    assign o_out_valid   = r_ov;
    assign o_out_chan    = r_ochan;
    assign o_window_mean = 12'(r_owm);
    assign o_peak_mean   = 12'(r_opm);
    assign o_ready_res   = r_ordy;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> (r_state == S_DIVF || r_state == S_DIVW || r_state == S_DIVP))
        else $error("divider finished outside a divide state");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without passing the output state");

    a_ready_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ready_res) |-> r_started[CIW'(o_out_chan)])
        else $error("ready result for a channel that has not started");

endmodule
